// ===== hw/rtl/bba_pkg.sv =====
// Shared constants and types of the binary buddy allocator.
// No dependencies; imported by bba_size, binary_buddy_allocator and the testbench.
package bba_pkg;

  localparam int MAX_ORDER    = 16;
  localparam int MIN_ORDER    = 5;
  localparam int HEADER_BYTES = 24;

  localparam int ORDER_W = 5;
  localparam int REQ_W   = 17;
  localparam int ADDR_W  = 16;
  localparam int UNIT_W  = MAX_ORDER - MIN_ORDER;
  localparam int UNITS   = 1 << UNIT_W;
  localparam int LINK_W  = UNIT_W + 1;
  localparam int STAT_W  = 2;

  localparam logic [LINK_W-1:0] NIL = LINK_W'(UNITS);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO     = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_BLOCK = 2'd2;

  // Per-unit bookkeeping word
  typedef struct packed {
    logic                 free;
    logic                 used;
    logic [ORDER_W-1:0]   order;
  } unit_info_t;

endpackage

// ===== hw/rtl/binary_buddy_allocator.sv =====
// Binary buddy allocator top level: sequencer, free-list heads, unit memories.
// Depends on bba_pkg and bba_size.
//
// Manages a pool of 2^pool_order bytes in 32-byte units. An allocate item
// returns the block offset plus the 24-byte header, or status zero-size /
// no-block; a free item returns zero and merges buddies. One item is handled
// at a time by a sequencer around three unit memories (info, next link,
// previous link), each with one read and one write port and a registered
// read. An allocate searches the free lists upward from the needed order,
// pops the hit and splits it down, pushing each upper half; a valid free
// merges with free buddies up to the pool order and pushes the result.
// Zero-size, oversized and ignored items go straight to the result.
// The sequencer passes through idle between items; a held result stalls it.
// After reset and after every pool_order write a clearing pass sweeps all
// 2048 entries of the info memory; no item is accepted until it ends.
// Writing pool_order clamps it to 5..16 and reinitializes the pool.
module binary_buddy_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [4:0]  cfg_wdata,   // pool_order
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,     // [16:0] req_size, [32:17] block_address
  input  logic [0:0]  s_tuser,     // [0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata      // [15:0] address, [17:16] status
);
  import bba_pkg::*;

  typedef enum logic [13:0] {
    S_CLEAR   = 14'b00000000000001,
    S_IDLE    = 14'b00000000000010,
    S_CHECK   = 14'b00000000000100,
    S_SEARCH  = 14'b00000000001000,
    S_POP     = 14'b00000000010000,
    S_SPLIT_A = 14'b00000000100000,
    S_SPLIT_B = 14'b00000001000000,
    S_A_END   = 14'b00000010000000,
    S_F_READ  = 14'b00000100000000,
    S_F_LOOP  = 14'b00001000000000,
    S_F_CHK   = 14'b00010000000000,
    S_F_PUSH  = 14'b00100000000000,
    S_RESULT  = 14'b01000000000000,
    S_SPARE   = 14'b10000000000000
  } state_t;

  state_t state;

  // Latched item and working registers
  logic                cmd_r;
  logic [REQ_W-1:0]    req_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [ORDER_W-1:0]  pool_order;
  logic [ORDER_W-1:0]  k;
  logic [UNIT_W-1:0]   u;
  logic [UNIT_W-1:0]   up;
  logic [UNIT_W-1:0]   bud;
  logic [UNIT_W-1:0]   clr_idx;
  logic [ADDR_W-1:0]   res_addr;
  logic [STAT_W-1:0]   res_status;
  logic [ADDR_W-1:0]   out_addr;
  logic [STAT_W-1:0]   out_status;
  logic [LINK_W-1:0]   head [0:MAX_ORDER];

  // Memories
  unit_info_t          info_mem [0:UNITS-1];
  logic [LINK_W-1:0]   next_mem [0:UNITS-1];
  logic [LINK_W-1:0]   prev_mem [0:UNITS-1];
  unit_info_t          info_rd;
  logic [LINK_W-1:0]   next_rd;
  logic [LINK_W-1:0]   prev_rd;
  logic [UNIT_W-1:0]   info_ra, next_ra, prev_ra;
  logic                info_we, next_we, prev_we;
  logic [UNIT_W-1:0]   info_wa, next_wa, prev_wa;
  unit_info_t          info_wd;
  logic [LINK_W-1:0]   next_wd, prev_wd;

  // Derived values
  logic [ORDER_W-1:0]  need;
  logic [ORDER_W-1:0]  k_dn;
  logic [UNIT_W-1:0]   split_up;
  logic [UNIT_W-1:0]   buddy;
  logic [ADDR_W-1:0]   off;
  logic [UNIT_W-1:0]   off_unit;
  logic                free_bad;
  logic                merge_ok;
  logic [ORDER_W-1:0]  cfg_clamp;
  logic [ORDER_W-1:0]  init_order;

  bba_size u_size (
    .req_size (req_r),
    .need     (need)
  );

  assign k_dn     = k - ORDER_W'(1);
  assign split_up = u ^ (UNIT_W'(1) << (k_dn - ORDER_W'(MIN_ORDER)));
  assign buddy    = u ^ (UNIT_W'(1) << (k - ORDER_W'(MIN_ORDER)));
  assign off      = addr_r - ADDR_W'(HEADER_BYTES);
  assign off_unit = off[ADDR_W-1:MIN_ORDER];
  assign free_bad = (addr_r < ADDR_W'(HEADER_BYTES)) || (off[MIN_ORDER-1:0] != '0) ||
                    ({1'b0, off} >= ((ADDR_W+1)'(1) << pool_order));
  assign merge_ok = info_rd.free && (info_rd.order == k);
  assign cfg_clamp = (cfg_wdata > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) :
                     (cfg_wdata < ORDER_W'(MIN_ORDER)) ? ORDER_W'(MIN_ORDER) : cfg_wdata;
  assign init_order = rst ? ORDER_W'(MAX_ORDER) : cfg_clamp;

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {6'd0, out_status, out_addr};

  // Memory ports driven by the sequencer
  always_comb begin
    info_ra = off_unit;
    next_ra = head[k][UNIT_W-1:0];
    prev_ra = buddy;
    info_we = 1'b0;
    next_we = 1'b0;
    prev_we = 1'b0;
    info_wa = u;
    next_wa = u;
    prev_wa = u;
    info_wd = '0;
    next_wd = NIL;
    prev_wd = NIL;
    unique case (state)
      S_CLEAR: begin
        info_we = 1'b1;
        info_wa = clr_idx;
        next_we = (clr_idx == '0);
        next_wa = clr_idx;
        prev_we = (clr_idx == '0);
        prev_wa = clr_idx;
        if (clr_idx == '0) begin
          info_wd = '{free: 1'b1, used: 1'b0, order: pool_order};
        end
      end
      S_F_LOOP: begin
        info_ra = buddy;
        next_ra = buddy;
      end
      S_POP: begin
        prev_we = (next_rd != NIL);
        prev_wa = next_rd[UNIT_W-1:0];
      end
      S_SPLIT_A: begin
        info_we = 1'b1;
        info_wa = split_up;
        info_wd = '{free: 1'b1, used: 1'b0, order: k_dn};
        next_we = 1'b1;
        next_wa = split_up;
        next_wd = head[k_dn];
        prev_we = 1'b1;
        prev_wa = split_up;
      end
      S_SPLIT_B: begin
        prev_we = (head[k] != NIL);
        prev_wa = head[k][UNIT_W-1:0];
        prev_wd = {1'b0, up};
      end
      S_A_END: begin
        info_we = 1'b1;
        info_wd = '{free: 1'b0, used: 1'b1, order: need};
      end
      S_F_READ: begin
        info_we = info_rd.used;
        info_wd = '{free: info_rd.free, used: 1'b0, order: info_rd.order};
      end
      S_F_CHK: begin
        if (merge_ok) begin
          next_we = (prev_rd != NIL);
          next_wa = prev_rd[UNIT_W-1:0];
          next_wd = next_rd;
          prev_we = (next_rd != NIL);
          prev_wa = next_rd[UNIT_W-1:0];
          prev_wd = prev_rd;
          info_we = 1'b1;
          info_wa = bud;
          info_wd = '{free: 1'b0, used: info_rd.used, order: info_rd.order};
        end
      end
      S_F_PUSH: begin
        info_we = 1'b1;
        info_wd = '{free: 1'b1, used: 1'b0, order: k};
        next_we = 1'b1;
        next_wd = head[k];
        prev_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Unit memories, registered reads
  always_ff @(posedge clk) begin
    if (info_we) begin
      info_mem[info_wa] <= info_wd;
    end
    info_rd <= info_mem[info_ra];
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    next_rd <= next_mem[next_ra];
  end

  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    prev_rd <= prev_mem[prev_ra];
  end

  // Raise the result item when the sequencer hands it over, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_RESULT) && !cfg_wen && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Sequencer and list heads
  always_ff @(posedge clk) begin
    if (rst || cfg_wen) begin
      pool_order <= init_order;
      for (int i = 0; i <= MAX_ORDER; i++) begin
        head[i] <= (ORDER_W'(i) == init_order) ? LINK_W'(0) : NIL;
      end
      clr_idx <= '0;
      state   <= S_CLEAR;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + UNIT_W'(1);
          if (clr_idx == UNIT_W'(UNITS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            cmd_r  <= s_tuser[0];
            req_r  <= s_tdata[16:0];
            addr_r <= s_tdata[32:17];
            state  <= S_CHECK;
          end
        end
        S_CHECK: begin
          res_addr <= '0;
          if (cmd_r == CMD_FREE) begin
            res_status <= ST_OK;
            u <= off_unit;
            state <= free_bad ? S_RESULT : S_F_READ;
          end else if (req_r == '0) begin
            res_status <= ST_ZERO;
            state      <= S_RESULT;
          end else if (need > pool_order) begin
            res_status <= ST_NO_BLOCK;
            state      <= S_RESULT;
          end else begin
            res_status <= ST_OK;
            k     <= need;
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (k > pool_order) begin
            res_status <= ST_NO_BLOCK;
            state      <= S_RESULT;
          end else if (head[k] != NIL) begin
            u     <= head[k][UNIT_W-1:0];
            state <= S_POP;
          end else begin
            k <= k + ORDER_W'(1);
          end
        end
        S_POP: begin
          head[k] <= next_rd;
          state   <= (k > need) ? S_SPLIT_A : S_A_END;
        end
        S_SPLIT_A: begin
          k     <= k_dn;
          up    <= split_up;
          state <= S_SPLIT_B;
        end
        S_SPLIT_B: begin
          head[k] <= {1'b0, up};
          if (cmd_r == CMD_FREE) begin
            state <= S_RESULT;
          end else begin
            state <= (k > need) ? S_SPLIT_A : S_A_END;
          end
        end
        S_A_END: begin
          res_addr <= {u, {MIN_ORDER{1'b0}}} + ADDR_W'(HEADER_BYTES);
          state    <= S_RESULT;
        end
        S_F_READ: begin
          k     <= info_rd.order;
          state <= info_rd.used ? S_F_LOOP : S_RESULT;
        end
        S_F_LOOP: begin
          bud   <= buddy;
          state <= (k < pool_order) ? S_F_CHK : S_F_PUSH;
        end
        S_F_CHK: begin
          if (merge_ok) begin
            if (prev_rd == NIL) begin
              head[k] <= next_rd;
            end
            if (bud < u) begin
              u <= bud;
            end
            k     <= k + ORDER_W'(1);
            state <= S_F_LOOP;
          end else begin
            state <= S_F_PUSH;
          end
        end
        S_F_PUSH: begin
          up    <= u;
          state <= S_SPLIT_B;
        end
        S_RESULT: begin
          if (!m_tvalid || m_tready) begin
            out_addr   <= res_addr;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/bba_size.sv =====
// Request size to block order: ceil(log2(size + header)), at least MIN_ORDER.
// Depends on bba_pkg.
module bba_size (
  input  logic [bba_pkg::REQ_W-1:0]   req_size,
  output logic [bba_pkg::ORDER_W-1:0] need
);
  import bba_pkg::*;

  logic [REQ_W:0]     span;
  logic [ORDER_W-1:0] bits;

  // Bit length of (size + header - 1)
  always_comb begin
    span = {1'b0, req_size} + (REQ_W+1)'(HEADER_BYTES - 1);
    bits = '0;
    for (int i = 0; i <= REQ_W; i++) begin
      if (span[i]) begin
        bits = ORDER_W'(i + 1);
      end
    end
    need = (bits < ORDER_W'(MIN_ORDER)) ? ORDER_W'(MIN_ORDER) : bits;
  end

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for binary_buddy_allocator: directed, pool-order, random and back-pressure items.
// Depends on bba_pkg and the allocator RTL; keeps its own buddy-pool predictor.
`timescale 1ns / 100ps

module testbench;
  import bba_pkg::*;

  typedef struct {
    logic [ADDR_W-1:0] address;
    logic [STAT_W-1:0] status;
  } alloc_result_t;

  logic        clk;
  logic        rst;
  logic        cfg_wen;
  logic [4:0]  cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic [0:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;

  binary_buddy_allocator dut (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Predictor state of the pool
  int pool_bits;
  bit unit_is_free [UNITS];
  bit unit_in_use [UNITS];
  int unit_ord [UNITS];
  int nxt [UNITS];
  int prv [UNITS];
  int head [MAX_ORDER+1];

  alloc_result_t pending_results[$];
  int live_addrs[$];
  int errors = 0;
  int n_items = 0, n_alloc_ok = 0, n_no_block = 0, n_free_ok = 0, n_results = 0;
  int rx_hold = 0;
  bit rx_steady = 0;
  bit tx_steady = 0;

  function automatic void fl_push(int k, int u);
    prv[u] = NIL;
    nxt[u] = head[k];
    if (head[k] < NIL) prv[head[k]] = u;
    head[k] = u;
  endfunction

  function automatic void fl_unlink(int k, int u);
    if (prv[u] < NIL) nxt[prv[u]] = nxt[u];
    else head[k] = nxt[u];
    if (nxt[u] < NIL) prv[nxt[u]] = prv[u];
  endfunction

  // Clamp the order and rebuild the pool as one free block
  function automatic void pool_reset(int order);
    order = order & 31;
    if (order > MAX_ORDER) order = MAX_ORDER;
    if (order < MIN_ORDER) order = MIN_ORDER;
    pool_bits = order;
    for (int u = 0; u < UNITS; u++) begin
      unit_is_free[u] = 0;
      unit_in_use[u] = 0;
      unit_ord[u] = 0;
      nxt[u] = 0;
      prv[u] = 0;
    end
    for (int k = 0; k <= MAX_ORDER; k++) head[k] = NIL;
    unit_is_free[0] = 1;
    unit_ord[0] = pool_bits;
    nxt[0] = NIL;
    prv[0] = NIL;
    head[pool_bits] = 0;
    live_addrs.delete();
  endfunction

  function automatic void release_block(int addr);
    int off, u, k, boff, b, idx[$];
    if (addr < HEADER_BYTES) return;
    off = addr - HEADER_BYTES;
    if (off % (1 << MIN_ORDER) != 0) return;
    if (off >= (1 << pool_bits)) return;
    u = off >> MIN_ORDER;
    if (!unit_in_use[u]) return;
    unit_in_use[u] = 0;
    n_free_ok++;
    idx = live_addrs.find_first_index(x) with (x == addr);
    if (idx.size() > 0) live_addrs.delete(idx[0]);
    k = unit_ord[u];
    // merge upward while the buddy is free at the same order
    while (k < pool_bits) begin
      boff = off ^ (1 << k);
      b = boff >> MIN_ORDER;
      if (!(unit_is_free[b] && unit_ord[b] == k)) break;
      fl_unlink(k, b);
      unit_is_free[b] = 0;
      if (boff < off) off = boff;
      k++;
    end
    u = off >> MIN_ORDER;
    unit_is_free[u] = 1;
    unit_ord[u] = k;
    fl_push(k, u);
  endfunction

  function automatic alloc_result_t predict_item(bit cmd, int req, int addr);
    alloc_result_t r;
    int need, v, i, u, off, up;
    r.address = '0;
    r.status = ST_OK;
    if (cmd == CMD_FREE) begin
      release_block(addr);
      return r;
    end
    if (req == 0) begin
      r.status = ST_ZERO;
      return r;
    end
    need = 0;
    v = req + HEADER_BYTES - 1;
    while (v > 0) begin
      v >>= 1;
      need++;
    end
    if (need < MIN_ORDER) need = MIN_ORDER;
    for (i = need; i <= pool_bits; i++)
      if (head[i] < NIL) break;
    if (need > pool_bits || i > pool_bits) begin
      r.status = ST_NO_BLOCK;
      n_no_block++;
      return r;
    end
    u = head[i];
    fl_unlink(i, u);
    unit_is_free[u] = 0;
    off = u << MIN_ORDER;
    // split down, pushing each upper half
    while (i > need) begin
      i--;
      up = (off ^ (1 << i)) >> MIN_ORDER;
      unit_is_free[up] = 1;
      unit_in_use[up] = 0;
      unit_ord[up] = i;
      fl_push(i, up);
    end
    unit_in_use[u] = 1;
    unit_ord[u] = need;
    r.address = ADDR_W'(off + HEADER_BYTES);
    live_addrs.push_back(off + HEADER_BYTES);
    n_alloc_ok++;
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #36_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: long holds, steady stretches, random stalls
  initial begin
    m_tready = 0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        m_tready <= 0;
        rx_hold--;
      end else if (rx_steady) begin
        m_tready <= 1;
      end else if ($urandom_range(0, 99) < 4) begin
        m_tready <= 0;
        rx_hold = $urandom_range(8, 30);
      end else begin
        m_tready <= ($urandom_range(0, 99) < 70);
      end
    end
  end

  // Compare each result item with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item %h", m_tdata);
      end else begin
        alloc_result_t e;
        e = pending_results.pop_front();
        if (m_tdata[15:0] !== e.address || m_tdata[17:16] !== e.status) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected address %h status %0d, got address %h status %0d",
                     e.address, e.status, m_tdata[15:0], m_tdata[17:16]);
        end
      end
    end
  end

  // Offer one item and hold it until accepted, then idle for a random gap, possibly none
  task automatic send_item(bit cmd, int req, int addr);
    int gap, r;
    @(negedge clk);
    s_tvalid <= 1;
    s_tuser <= cmd;
    s_tdata <= {7'b0, addr[15:0], req[16:0]};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(predict_item(cmd, req, addr));
    n_items++;
    r = $urandom_range(0, 99);
    gap = (tx_steady || r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_pool_order(int value);
    drain();
    @(negedge clk);
    cfg_wen <= 1;
    cfg_wdata <= value[4:0];
    @(negedge clk);
    cfg_wen <= 0;
    pool_reset(value);
  endtask

  task automatic free_all_live();
    while (live_addrs.size() != 0) send_item(CMD_FREE, $urandom_range(0, 131071), live_addrs[0]);
  endtask

  // Random item: mostly well-formed alloc/free traffic, some noise
  task automatic random_item();
    int r, sz, a;
    r = $urandom_range(0, 99);
    if (r < 48) begin
      a = $urandom_range(0, 99);
      sz = (a < 70) ? $urandom_range(1, 200) : (a < 90) ? $urandom_range(1, 4000) :
           (a < 97) ? $urandom_range(1, 65536) : $urandom_range(0, 131071);
      send_item(CMD_ALLOC, sz, $urandom_range(0, 65535));
    end else if (r < 90 && live_addrs.size() > 0) begin
      send_item(CMD_FREE, $urandom_range(0, 131071),
                live_addrs[$urandom_range(0, live_addrs.size() - 1)]);
    end else if (r < 95) begin
      a = $urandom_range(0, 65535);
      if (r < 93) a = ((a >> MIN_ORDER) << MIN_ORDER) + HEADER_BYTES;
      send_item(CMD_FREE, $urandom_range(0, 131071), a & 16'hFFFF);
    end else begin
      send_item(CMD_ALLOC, 0, $urandom_range(0, 65535));
    end
  endtask

  task automatic test_directed();
    int a;
    send_item(CMD_ALLOC, 0, 16'hFFFF);
    send_item(CMD_ALLOC, 1, 0);
    send_item(CMD_ALLOC, 8, 0);
    send_item(CMD_ALLOC, 9, 0);
    send_item(CMD_ALLOC, 65536, 0);
    send_item(CMD_ALLOC, 131071, 0);
    send_item(CMD_ALLOC, 65512, 0);
    send_item(CMD_ALLOC, 2000, 0);
    send_item(CMD_FREE, 0, 0);
    send_item(CMD_FREE, 0, 23);
    send_item(CMD_FREE, 0, 25);
    send_item(CMD_FREE, 0, 65535);
    a = live_addrs[0];
    send_item(CMD_FREE, 131071, a);
    send_item(CMD_FREE, 0, a);
    free_all_live();
    send_item(CMD_ALLOC, 65512, 0);
    free_all_live();
    send_item(CMD_ALLOC, 65513, 0);
  endtask

  task automatic test_pool_orders();
    write_pool_order(5);
    send_item(CMD_ALLOC, 8, 0);
    send_item(CMD_ALLOC, 1, 0);
    free_all_live();
    send_item(CMD_ALLOC, 9, 0);
    write_pool_order(31);
    send_item(CMD_ALLOC, 65512, 0);
    write_pool_order(0);
    send_item(CMD_ALLOC, 8, 0);
  endtask

  task automatic test_random(int order, int count);
    write_pool_order(order);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) tx_steady = ($urandom_range(0, 3) == 0);
      if (i % 150 == 0) rx_steady = ($urandom_range(0, 3) == 0);
      random_item();
    end
    tx_steady = 0;
    rx_steady = 0;
  endtask

  task automatic test_backpressure();
    tx_steady = 1;
    rx_hold = 400;
    for (int i = 0; i < 40; i++) random_item();
    tx_steady = 0;
    drain();
  endtask

  initial begin
    rst = 1;
    cfg_wen = 0;
    cfg_wdata = '0;
    s_tvalid = 0;
    s_tdata = '0;
    s_tuser = '0;
    pool_reset(16);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_directed();
    test_pool_orders();
    test_random(16, 400);
    test_backpressure();
    test_random(8, 250);
    test_random(11, 300);
    test_random(6, 150);
    test_random(16, 350);
    drain();
    $display("Ran %0d items, %0d result items: %0d allocations granted, %0d refused, %0d frees.",
             n_items, n_results, n_alloc_ok, n_no_block, n_free_ok);
    $display("Pool orders 5 to 16 with clamped writes, stalls and a long receiver hold.");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
